[rtl/rvid_pkg.sv]
// Opcode, funct3 and decoded-result definitions for the RV32I instruction decoder.
`timescale 1ns / 1ps

package rvid_pkg;

  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_FENCE  = 7'b0001111;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

  localparam logic [2:0] F3_SLL  = 3'b001;
  localparam logic [2:0] F3_SR   = 3'b101;
  localparam logic [2:0] F3_PRIV = 3'b000;

  typedef struct packed {
    logic [4:0]         rd;
    logic [4:0]         rs1;
    logic [4:0]         rs2;
    logic signed [31:0] imm;
    logic [15:0]        type_code;
    logic               bad;
  } decode_t;

endpackage

[rtl/rv32i_instruction_decoder.sv]
// Top level of the RV32I instruction decoder: input register, decode logic, result register.
`timescale 1ns / 1ps

// RV32I instruction decoder. Pulse start with an instruction word; busy never rises, so a
// new word can be issued every cycle. Each word passes through the input register and then
// the result register, and its result is flagged there by a one-cycle done
// strobe; the receiver must take it then, as results cannot be held off. Outputs are
// rd/rs1/rs2 (zero where the format has none), the sign-extended immediate (shift amount
// for shift-immediates, zero for R-type), a 16-bit type code and bad_opcode, which marks an
// unsupported opcode and forces every other field to zero.
module rv32i_instruction_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        instruction_word,
  output logic               done,
  output logic [4:0]         dest_reg,
  output logic [4:0]         src_reg_one,
  output logic [4:0]         src_reg_two,
  output logic signed [31:0] imm_value,
  output logic [15:0]        type_code,
  output logic               bad_opcode
);
  import rvid_pkg::*;

  logic        in_valid;
  logic [31:0] iw_q;
  decode_t     dec_next;

  logic [6:0] opc;
  logic [2:0] f3;
  logic       keep_all;

  assign busy = 1'b0;
  assign opc  = iw_q[6:0];
  assign f3   = iw_q[14:12];

  // Full type code survives only for shift-immediates, R-type and the privileged system op.
  always_comb begin
    keep_all = ((opc == OPC_OPIMM) && (f3 inside {F3_SLL, F3_SR})) ||
               (opc == OPC_OP) ||
               ((opc == OPC_SYSTEM) && (f3 == F3_PRIV));
  end

  always_comb begin
    dec_next = '0;
    case (opc)
      OPC_LOAD, OPC_FENCE, OPC_OPIMM, OPC_JALR, OPC_SYSTEM: begin
        dec_next.rd  = iw_q[11:7];
        dec_next.rs1 = iw_q[19:15];
        if ((opc == OPC_OPIMM) && (f3 inside {F3_SLL, F3_SR})) begin
          dec_next.imm = {27'd0, iw_q[24:20]};
        end else begin
          dec_next.imm = {{20{iw_q[31]}}, iw_q[31:20]};
        end
        dec_next.type_code = {keep_all ? iw_q[30:25] : 6'd0, f3, opc};
      end
      OPC_AUIPC, OPC_LUI: begin
        dec_next.rd        = iw_q[11:7];
        dec_next.imm       = {iw_q[31:12], 12'd0};
        dec_next.type_code = {9'd0, opc};
      end
      OPC_STORE: begin
        dec_next.rs1       = iw_q[19:15];
        dec_next.rs2       = iw_q[24:20];
        dec_next.imm       = {{20{iw_q[31]}}, iw_q[31:25], iw_q[11:7]};
        dec_next.type_code = {6'd0, f3, opc};
      end
      OPC_OP: begin
        dec_next.rd        = iw_q[11:7];
        dec_next.rs1       = iw_q[19:15];
        dec_next.rs2       = iw_q[24:20];
        dec_next.type_code = {iw_q[30:25], f3, opc};
      end
      OPC_BRANCH: begin
        dec_next.rs1       = iw_q[19:15];
        dec_next.rs2       = iw_q[24:20];
        dec_next.imm       = {{20{iw_q[31]}}, iw_q[7], iw_q[30:25], iw_q[11:8], 1'b0};
        dec_next.type_code = {6'd0, f3, opc};
      end
      OPC_JAL: begin
        dec_next.rd        = iw_q[11:7];
        dec_next.imm       = {{12{iw_q[31]}}, iw_q[19:12], iw_q[20], iw_q[30:21], 1'b0};
        dec_next.type_code = {9'd0, opc};
      end
      default: begin
        dec_next.bad = 1'b1;
      end
    endcase
  end

  // Capture each transaction into the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    if (start && !busy) begin
      iw_q <= instruction_word;
    end
  end

  // Advance the decoded word into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    if (in_valid) begin
      dest_reg    <= dec_next.rd;
      src_reg_one <= dec_next.rs1;
      src_reg_two <= dec_next.rs2;
      imm_value   <= dec_next.imm;
      type_code   <= dec_next.type_code;
      bad_opcode  <= dec_next.bad;
    end
  end

`ifndef ASSERT_OFF
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid |=> done)
    else $error("decoded transaction did not produce a done strobe");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (done && bad_opcode) |-> (dest_reg == 5'd0 && src_reg_one == 5'd0 &&
                              src_reg_two == 5'd0 && imm_value == 32'sd0 &&
                              type_code == 16'd0))
    else $error("bad opcode result carries nonzero fields");

  a_type_opcode: assert property (@(posedge clk) disable iff (rst)
    in_valid |=> (bad_opcode || type_code[6:0] == $past(iw_q[6:0])))
    else $error("type code opcode does not match instruction word");
`endif

endmodule

[tb/tb_rv32i_instruction_decoder.sv]
// Self-checking testbench for the RV32I instruction decoder: directed and random words.
`timescale 1ns / 1ps

module tb_rv32i_instruction_decoder;
  import rvid_pkg::*;

  localparam int NUM_RANDOM = 1650;
  localparam int MAX_PRINTS = 40;

  typedef struct {
    logic [31:0] word;
    decode_t     decoded;
  } pending_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [31:0]        instruction_word = '0;
  logic               busy;
  logic               done;
  logic [4:0]         dest_reg;
  logic [4:0]         src_reg_one;
  logic [4:0]         src_reg_two;
  logic signed [31:0] imm_value;
  logic [15:0]        type_code;
  logic               bad_opcode;

  pending_t pending_decodes[$];
  int       mismatch_count = 0;
  int       result_count = 0;
  int       sent_count = 0;
  int       bad_sent = 0;
  int       shift_sent = 0;
  bit       idle_off = 1'b0;

  rv32i_instruction_decoder uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .instruction_word(instruction_word),
    .done(done),
    .dest_reg(dest_reg),
    .src_reg_one(src_reg_one),
    .src_reg_two(src_reg_two),
    .imm_value(imm_value),
    .type_code(type_code),
    .bad_opcode(bad_opcode)
  );

  always #5 clk = ~clk;

  function automatic logic [6:0] opcode_at(int idx);
    case (idx)
      0:       return OPC_LOAD;
      1:       return OPC_FENCE;
      2:       return OPC_OPIMM;
      3:       return OPC_AUIPC;
      4:       return OPC_STORE;
      5:       return OPC_OP;
      6:       return OPC_LUI;
      7:       return OPC_BRANCH;
      8:       return OPC_JALR;
      9:       return OPC_JAL;
      default: return OPC_SYSTEM;
    endcase
  endfunction

  function automatic bit is_shift_imm(logic [31:0] w);
    return w[6:0] == OPC_OPIMM && (w[14:12] == F3_SLL || w[14:12] == F3_SR);
  endfunction

  // Keep the funct7 bits only for shift-immediates, R-type and the privileged system group.
  function automatic logic [15:0] pack_type_code(logic [6:0] opc, logic [2:0] f3,
                                                 logic [6:0] upper);
    logic [15:0] full;
    logic [9:0]  low;
    full = {upper[5:0], f3, opc};
    low = full[9:0];
    if (low == {F3_SLL, OPC_OPIMM} || low == {F3_SR, OPC_OPIMM} || low[6:0] == OPC_OP ||
        low == {F3_PRIV, OPC_SYSTEM})
      return full;
    return {6'b0, low};
  endfunction

  function automatic decode_t predict_decode(logic [31:0] w);
    decode_t    d;
    logic [6:0] opc;
    logic [2:0] f3;
    opc = w[6:0];
    f3 = w[14:12];
    d = '0;
    case (opc)
      OPC_LOAD, OPC_FENCE, OPC_OPIMM, OPC_JALR, OPC_SYSTEM: begin
        d.rd = w[11:7];
        d.rs1 = w[19:15];
        d.imm = {{20{w[31]}}, w[31:20]};
        d.type_code = pack_type_code(opc, f3, w[31:25]);
        if (is_shift_imm(w))
          d.imm = {27'b0, w[24:20]};
      end
      OPC_AUIPC, OPC_LUI: begin
        d.rd = w[11:7];
        d.imm = {w[31:12], 12'b0};
        d.type_code = pack_type_code(opc, '0, '0);
      end
      OPC_STORE: begin
        d.rs1 = w[19:15];
        d.rs2 = w[24:20];
        d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
        d.type_code = pack_type_code(opc, f3, '0);
      end
      OPC_OP: begin
        d.rd = w[11:7];
        d.rs1 = w[19:15];
        d.rs2 = w[24:20];
        d.type_code = pack_type_code(opc, f3, w[31:25]);
      end
      OPC_BRANCH: begin
        d.rs1 = w[19:15];
        d.rs2 = w[24:20];
        d.imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
        d.type_code = pack_type_code(opc, f3, '0);
      end
      OPC_JAL: begin
        d.rd = w[11:7];
        d.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
        d.type_code = pack_type_code(opc, '0, '0);
      end
      default: d.bad = 1'b1;
    endcase
    return d;
  endfunction

  function automatic int draw_gap();
    return idle_off ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] word,
                                 input logic [31:0] got, input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("%0t: mismatch on %0s for word %h: got %h, expected %h",
               $time, what, word, got, want);
  endtask

  // Hold start until the transaction is taken, then record what the decoder should return.
  task automatic send_word(input logic [31:0] w);
    int       gap;
    pending_t entry;
    gap = draw_gap();
    start <= 1'b1;
    instruction_word <= w;
    do @(posedge clk); while (busy);
    entry.word = w;
    entry.decoded = predict_decode(w);
    pending_decodes.push_back(entry);
    sent_count++;
    if (entry.decoded.bad)
      bad_sent++;
    if (is_shift_imm(w))
      shift_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : check_result
    pending_t want;
    if (!rst && done) begin
      if (pending_decodes.size() == 0) begin
        report_mismatch("result with nothing pending", '0, '0, '0);
      end else begin
        want = pending_decodes.pop_front();
        result_count++;
        if (dest_reg !== want.decoded.rd)
          report_mismatch("dest_reg", want.word, {27'd0, dest_reg},
                          {27'd0, want.decoded.rd});
        if (src_reg_one !== want.decoded.rs1)
          report_mismatch("src_reg_one", want.word, {27'd0, src_reg_one},
                          {27'd0, want.decoded.rs1});
        if (src_reg_two !== want.decoded.rs2)
          report_mismatch("src_reg_two", want.word, {27'd0, src_reg_two},
                          {27'd0, want.decoded.rs2});
        if (imm_value !== want.decoded.imm)
          report_mismatch("imm_value", want.word, imm_value, want.decoded.imm);
        if (type_code !== want.decoded.type_code)
          report_mismatch("type_code", want.word, {16'd0, type_code},
                          {16'd0, want.decoded.type_code});
        if (bad_opcode !== want.decoded.bad)
          report_mismatch("bad_opcode", want.word, {31'd0, bad_opcode},
                          {31'd0, want.decoded.bad});
      end
    end
  end

  // Every supported opcode with all upper bits set and with all upper bits clear.
  task automatic test_formats();
    for (int i = 0; i < 11; i++) begin
      send_word({25'h1FFFFFF, opcode_at(i)});
      send_word({25'h0000000, opcode_at(i)});
    end
  endtask

  task automatic test_special_cases();
    // shift-immediates with upper immediate bits that must be dropped
    send_word({7'b0100000, 5'd31, 5'd7, F3_SR, 5'd9, OPC_OPIMM});
    send_word({7'b1111111, 5'd17, 5'd31, F3_SLL, 5'd1, OPC_OPIMM});
    // privileged system group with nonzero funct7 bits
    send_word({7'b0011000, 5'd2, 5'd0, F3_PRIV, 5'd0, OPC_SYSTEM});
    // unsupported opcodes at both extremes of the word
    send_word(32'hFFFFFFFF);
    send_word(32'h00000000);
  endtask

  task automatic test_random_valid(input int count);
    logic [31:0] w;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0)
        idle_off = ($urandom_range(0, 3) == 0);
      w = $urandom();
      w[6:0] = opcode_at($urandom_range(0, 10));
      // bias toward shift-immediates so both funct7 forms show up often
      if ($urandom_range(0, 7) == 0) begin
        w[6:0] = OPC_OPIMM;
        w[14:12] = $urandom_range(0, 1) ? F3_SLL : F3_SR;
      end
      send_word(w);
    end
  endtask

  task automatic test_random_noise(input int count);
    logic [31:0] w;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0)
        idle_off = ($urandom_range(0, 3) == 0);
      w = $urandom();
      // flip one opcode bit of a supported opcode to land just beside it
      if ($urandom_range(0, 1) == 0)
        w[6:0] = opcode_at($urandom_range(0, 10)) ^ (7'b1 << $urandom_range(0, 6));
      send_word(w);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_formats();
    test_special_cases();
    test_random_valid(NUM_RANDOM * 85 / 100);
    test_random_noise(NUM_RANDOM - NUM_RANDOM * 85 / 100);
    start <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    // drain: catch any stray strobe after the last transaction
    repeat (4) @(posedge clk);
    $display("run covered %0d instruction words and %0d checked results", sent_count,
             result_count);
    $display("of those, %0d had unsupported opcodes and %0d were shift-immediates",
             bad_sent, shift_sent);
    if (mismatch_count == 0)
      $display("tb_rv32i_instruction_decoder: clean");
    else
      $display("tb_rv32i_instruction_decoder: errors");
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout waiting for the decoder");
    $display("tb_rv32i_instruction_decoder: errors");
    $finish;
  end

endmodule
